### rtl/fir_pkg.sv
// Shared types and constants for the direct-form FIR filter.
// No dependencies; every other file in rtl/ refers to this package.
package fir_pkg;

    localparam int TAPS_DEFAULT = 64;

    localparam int SAMPLE_W = 16;  // Q1.15
    localparam int COEF_W   = 18;  // Q2.16
    localparam int INDEX_W  = 6;
    localparam int PROD_W   = SAMPLE_W + COEF_W;  // Q3.31, exact
    localparam int FRAC_DROP = 16;                // Q3.31 -> Q1.15

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } fir_state_t;

    // Broadcast from the controller to every tap cell
    typedef struct packed
    {
        logic                       shift;
        logic                       clear;
        logic                       coef_we;
        logic [INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } fir_cell_ctrl_t;

endpackage

### rtl/fir_in_if.sv
// Input channel of the FIR filter: valid/ready plus one input item.
// Depends on fir_pkg for field widths.
interface fir_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic signed [fir_pkg::SAMPLE_W-1:0]    sample_in;
    logic [fir_pkg::INDEX_W-1:0]            coef_index;
    logic signed [fir_pkg::COEF_W-1:0]      coef_value;

    modport source (output valid, op, sample_in, coef_index, coef_value, input ready);
    modport sink   (input valid, op, sample_in, coef_index, coef_value, output ready);
endinterface

### rtl/fir_out_if.sv
// Output channel of the FIR filter: valid/ready plus one result item.
// Depends on fir_pkg for field widths.
interface fir_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fir_pkg::SAMPLE_W-1:0]    sample_out;
    logic                                   saturated;

    modport source (output valid, sample_out, saturated, input ready);
    modport sink   (input valid, sample_out, saturated, output ready);
endinterface

### rtl/fir_filter_direct_form_top.sv
// Top level of the direct-form FIR filter: controller, tap chain, output register.
// Depends on fir_pkg, fir_in_if, fir_out_if and fir_cell.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------------
//  in_ch     | in        | valid / ready      | op, sample_in, coef_index, coef_value
//  out_ch    | out       | valid / ready      | sample_out, saturated
//  cfg       | in        | cfg_we (no stall)  | cfg_wdata = bypass
//
// A filtered sample passes from acceptance to out_ch.valid through the tap chain: the partial
// sum ripples through the TAPS cells one per cycle, plus product, result and output
// registers. A bypassed sample goes through the result and output registers only; a
// coefficient write keeps in_ch.ready high. One item is in flight at a time. Reset clears
// history and coefficients and sets bypass. While out_ch stalls, the finished result waits
// in the result register and in_ch.ready stays low.
module fir_filter_direct_form_top #(
    parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    fir_in_if.sink      in_ch,
    fir_out_if.source   out_ch
);

    localparam int ACC_W  = fir_pkg::PROD_W + $clog2(TAPS);
    localparam int SH_W   = ACC_W + 1 - fir_pkg::FRAC_DROP;
    localparam int LAST   = TAPS + 1;
    localparam int CNT_W  = $clog2(TAPS + 2);
    localparam logic signed [ACC_W:0]  ROUND_HALF = (ACC_W + 1)'(32768);
    localparam logic signed [SH_W-1:0] SAT_MAX    = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_MIN    = SH_W'(-32768);

    fir_pkg::fir_state_t state_reg;
    fir_pkg::fir_state_t state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                bypass_reg;

    logic signed [fir_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                                res_sat_reg;
    logic                                out_valid_reg;
    logic signed [fir_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                out_sat_reg;

    logic in_accept;
    logic out_free;
    logic run_last;
    logic load_bypass;
    logic push_out;

    fir_pkg::fir_cell_ctrl_t cell_ctrl;

    logic signed [fir_pkg::SAMPLE_W-1:0] hist_link [TAPS];
    logic signed [ACC_W-1:0]             psum_link [TAPS];

    logic signed [ACC_W:0]               rnd_sum;
    logic signed [SH_W-1:0]              rnd_val;
    logic signed [fir_pkg::SAMPLE_W-1:0] sat_sample;
    logic                                sat_flag;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign run_last  = (cnt_reg == CNT_W'(LAST));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                if (in_accept && (in_ch.op == fir_pkg::OP_FILTER))
                begin
                    state_next = bypass_reg ? fir_pkg::ST_DONE : fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = fir_pkg::ST_DONE;
                end
            end
            fir_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        in_ch.ready = 1'b0;
        load_bypass = 1'b0;
        push_out    = 1'b0;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                load_bypass = in_ch.valid && (in_ch.op == fir_pkg::OP_FILTER) && bypass_reg;
                cnt_next    = '0;
            end
            fir_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            fir_pkg::ST_DONE:
            begin
                push_out = out_free;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl.shift      = in_accept && (in_ch.op == fir_pkg::OP_FILTER) && !bypass_reg;
        cell_ctrl.clear      = in_accept && (in_ch.op == fir_pkg::OP_COEF);
        cell_ctrl.coef_we    = in_accept && (in_ch.op == fir_pkg::OP_COEF);
        cell_ctrl.coef_index = in_ch.coef_index;
        cell_ctrl.coef_value = in_ch.coef_value;
    end

    genvar t;
    generate
        for (t = 0; t < TAPS; t++)
        begin : g_tap
            if (t == 0)
            begin : g_head
                fir_cell #(
                    .ACC_W (ACC_W),
                    .INDEX (t)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .hist_in  (in_ch.sample_in),
                    .psum_in  ('0),
                    .hist_out (hist_link[t]),
                    .psum_out (psum_link[t])
                );
            end
            else
            begin : g_body
                fir_cell #(
                    .ACC_W (ACC_W),
                    .INDEX (t)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .hist_in  (hist_link[t-1]),
                    .psum_in  (psum_link[t-1]),
                    .hist_out (hist_link[t]),
                    .psum_out (psum_link[t])
                );
            end
        end
    endgenerate

    // Round half up to Q1.15, then clip
    always_comb
    begin
        rnd_sum    = (ACC_W + 1)'(psum_link[TAPS-1]) + ROUND_HALF;
        rnd_val    = rnd_sum[ACC_W:fir_pkg::FRAC_DROP];
        sat_flag   = 1'b0;
        sat_sample = rnd_val[fir_pkg::SAMPLE_W-1:0];
        if (rnd_val > SAT_MAX)
        begin
            sat_sample = SAT_MAX[fir_pkg::SAMPLE_W-1:0];
            sat_flag   = 1'b1;
        end
        else if (rnd_val < SAT_MIN)
        begin
            sat_sample = SAT_MIN[fir_pkg::SAMPLE_W-1:0];
            sat_flag   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fir_pkg::ST_IDLE;
            cnt_reg       <= '0;
            bypass_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                bypass_reg <= cfg_wdata;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_bypass)
        begin
            res_sample_reg <= in_ch.sample_in;
            res_sat_reg    <= 1'b0;
        end
        else if ((state_reg == fir_pkg::ST_RUN) && run_last)
        begin
            res_sample_reg <= sat_sample;
            res_sat_reg    <= sat_flag;
        end
        if (push_out)
        begin
            out_sample_reg <= res_sample_reg;
            out_sat_reg    <= res_sat_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.saturated  = out_sat_reg;

endmodule

### rtl/fir_cell.sv
// One tap of the FIR chain: history word, coefficient, registered product
// and a partial sum passed on to the next tap. Depends on fir_pkg.
module fir_cell #(
    parameter int ACC_W = 42,
    parameter int INDEX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir_pkg::fir_cell_ctrl_t             ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] hist_in,
    input  logic signed [ACC_W-1:0]             psum_in,
    output logic signed [fir_pkg::SAMPLE_W-1:0] hist_out,
    output logic signed [ACC_W-1:0]             psum_out
);

    logic signed [fir_pkg::SAMPLE_W-1:0] hist_reg;
    logic signed [fir_pkg::SAMPLE_W-1:0] hist_next;
    logic signed [fir_pkg::COEF_W-1:0]   coef_reg;
    logic signed [fir_pkg::COEF_W-1:0]   coef_next;
    logic signed [fir_pkg::PROD_W-1:0]   prod_reg;
    logic signed [fir_pkg::PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]             psum_reg;
    logic signed [ACC_W-1:0]             psum_next;
    logic                                hit;

    assign hit = ctrl.coef_we && (int'(ctrl.coef_index) == INDEX);

    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = '0;
        end
        else if (ctrl.shift)
        begin
            hist_next = hist_in;
        end
    end

    assign coef_next = hit ? ctrl.coef_value : coef_reg;

    assign prod_next = fir_pkg::PROD_W'(hist_reg) * fir_pkg::PROD_W'(coef_reg);
    assign psum_next = psum_in + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            coef_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            coef_reg <= coef_next;
        end
    end

    // Products and partial sums run freely; the controller samples the end
    // of the chain once the history has been still long enough.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign hist_out = hist_reg;
    assign psum_out = psum_reg;

endmodule

### rtl/fir_checker.sv
// Port-level checks for the FIR filter, bound to fir_filter_direct_form_top.
// Depends on fir_pkg for field widths.
module fir_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                in_op,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    input logic                                saturated
);

    localparam logic signed [fir_pkg::SAMPLE_W-1:0] CLIP_HI = 16'sh7fff;
    localparam logic signed [fir_pkg::SAMPLE_W-1:0] CLIP_LO = 16'sh8000;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
        else $error("stalled result changed or dropped");

    // Accepting a sample transaction closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == fir_pkg::OP_FILTER) |=> !in_ready)
        else $error("input reopened while a sample is in flight");

    // A clipped result sits at one of the rails
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (sample_out == CLIP_HI) || (sample_out == CLIP_LO))
        else $error("saturated flag with an unclipped value");

    // New results appear only after a spell with the input closed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a sample in flight");

endmodule

bind fir_filter_direct_form_top fir_checker u_fir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.op),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out),
    .saturated  (out_ch.saturated)
);
